// ===== src/stlm_pkg.sv =====
// Package for the sorted two-list merge core.
// Holds the item kind codes, field widths and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package stlm_pkg;

    localparam int DATA_W             = 32;
    localparam int KIND_W             = 2;
    localparam int DEFAULT_LIST_DEPTH = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_A = 2'd0,
        KIND_LOAD_B = 2'd1,
        KIND_MERGE  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

endpackage

// ===== src/stlm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for both list stores of the merge core; no dependencies.
`timescale 1ns / 1ps

module stlm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sorted_two_list_merge_core.sv =====
// Top level of the sorted two-list merge core.
// Depends on stlm_pkg and stlm_ram (one instance per list store).
//
// Usage: input items arrive on the s_axis channel. tuser carries the kind
// (load list A, load list B, merge, or an ignored code) and tdata carries the
// value of a load. While idle, a load writes one element per cycle into its
// list store and gives no result; a load into a full list is dropped. A merge
// item streams every stored element out on the m_axis channel in ascending
// signed order when each list is sorted, taking list B on a tie, and marks
// the final element with tlast. Both counts then clear. A merge of two empty
// lists gives no result. The input is blocked for the whole merge.
// The first heads are already read while idle; the merge item moves the state
// to ST_MERGE, and the first element is then registered into the output
// register. When the receiver never stalls, one element leaves per cycle,
// and the counts clear after the last one. The rate is set by the single read
// port of each list RAM, which fetches the next head once per emitted element.
// Reset clears the counts and the output valid; list contents are unknown.
// When the receiver stalls, the output register holds its item and the merge
// pauses. Loads are still taken while a final result waits in that register.
`timescale 1ns / 1ps

module sorted_two_list_merge_core #(
    parameter int LIST_DEPTH = stlm_pkg::DEFAULT_LIST_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [stlm_pkg::DATA_W-1:0] i_s_axis_tdata,  // [31:0] item_value
    input  logic [stlm_pkg::KIND_W-1:0] i_s_axis_tuser,  // [1:0] kind
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [stlm_pkg::DATA_W-1:0] o_m_axis_tdata,  // [31:0] out_value
    output logic                        o_m_axis_tlast   // out_last
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MERGE = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_ia, n_ia, r_ib, n_ib;
    logic          r_out_valid, n_out_valid;
    logic [stlm_pkg::DATA_W-1:0] r_out_data, n_out_data;
    logic          r_out_last, n_out_last;

    logic s_acc, out_free, a_ok, b_ok, take_a, emit;
    logic we_a, we_b;
    logic [stlm_pkg::DATA_W-1:0] rdata_a, rdata_b;
    logic [CW:0] pos_next, total;
    stlm_pkg::t_kind kind;

    assign kind            = stlm_pkg::t_kind'(i_s_axis_tuser);
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    assign we_a = s_acc && (kind == stlm_pkg::KIND_LOAD_A) && (r_cnt_a < DEPTH_C);
    assign we_b = s_acc && (kind == stlm_pkg::KIND_LOAD_B) && (r_cnt_b < DEPTH_C);

    assign a_ok     = r_ia < r_cnt_a;
    assign b_ok     = r_ib < r_cnt_b;
    assign take_a   = a_ok && (!b_ok || ($signed(rdata_a) < $signed(rdata_b)));
    assign emit     = (r_state == ST_MERGE) && (a_ok || b_ok) && out_free;
    assign pos_next = {1'b0, r_ia} + {1'b0, r_ib} + (CW + 1)'(1);
    assign total    = {1'b0, r_cnt_a} + {1'b0, r_cnt_b};

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_ia        = r_ia;
        n_ib        = r_ib;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        unique case (r_state)
            ST_IDLE: begin
                if (we_a) begin
                    n_cnt_a = r_cnt_a + CW'(1);
                end
                if (we_b) begin
                    n_cnt_b = r_cnt_b + CW'(1);
                end
                if (s_acc && (kind == stlm_pkg::KIND_MERGE) && (total != '0)) begin
                    n_state = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (emit) begin
                    n_out_valid = 1'b1;
                    n_out_data  = take_a ? rdata_a : rdata_b;
                    n_out_last  = (pos_next == total);
                    if (take_a) begin
                        n_ia = r_ia + CW'(1);
                    end else begin
                        n_ib = r_ib + CW'(1);
                    end
                end else if (!a_ok && !b_ok) begin
                    n_state = ST_IDLE;
                    n_cnt_a = '0;
                    n_cnt_b = '0;
                    n_ia    = '0;
                    n_ib    = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_ia        <= '0;
            r_ib        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_ia        <= n_ia;
            r_ib        <= n_ib;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    stlm_ram #(
        .WIDTH  (stlm_pkg::DATA_W),
        .DEPTH  (LIST_DEPTH),
        .ADDR_W (AW)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (n_ia[AW-1:0]),
        .o_rdata (rdata_a)
    );

    stlm_ram #(
        .WIDTH  (stlm_pkg::DATA_W),
        .DEPTH  (LIST_DEPTH),
        .ADDR_W (AW)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (n_ib[AW-1:0]),
        .o_rdata (rdata_b)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= DEPTH_C) && (r_cnt_b <= DEPTH_C))
        else $error("list count exceeds depth");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ia <= r_cnt_a) && (r_ib <= r_cnt_b))
        else $error("read index passed list count");

    a_merge_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (kind == stlm_pkg::KIND_MERGE) && (total != '0) |=> r_state == ST_MERGE)
        else $error("merge item did not start a merge");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && (pos_next == total) |=> (r_ia == r_cnt_a) && (r_ib == r_cnt_b))
        else $error("last flag set while elements remain");

endmodule

// ===== sim/stlm_merge_checker.sv =====
// Checker for the sorted two-list merge core: watches both stream channels,
// keeps its own copy of the two list stores and predicts each merged run.
// Depends on stlm_pkg for the kind codes and field widths.
`timescale 1ns / 1ps

module stlm_merge_checker #(
    parameter int LIST_DEPTH = stlm_pkg::DEFAULT_LIST_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    input  logic                        i_s_axis_tready,
    input  logic [stlm_pkg::DATA_W-1:0] i_s_axis_tdata,   // [31:0] item_value
    input  logic [stlm_pkg::KIND_W-1:0] i_s_axis_tuser,   // [1:0] kind
    input  logic                        i_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    input  logic [stlm_pkg::DATA_W-1:0] i_m_axis_tdata,   // [31:0] out_value
    input  logic                        i_m_axis_tlast,   // out_last
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_merges,
    output int                          o_results
);

    typedef struct packed {
        logic [stlm_pkg::DATA_W-1:0] value;
        logic                        last;
    } t_merged;

    logic signed [stlm_pkg::DATA_W-1:0] list_a [LIST_DEPTH];
    logic signed [stlm_pkg::DATA_W-1:0] list_b [LIST_DEPTH];
    int                                 fill_a;
    int                                 fill_b;
    t_merged                            merged_q [$];
    t_merged                            oldest;
    logic [stlm_pkg::DATA_W-1:0]        head;
    int                                 ia;
    int                                 ib;
    int                                 total;
    int                                 fails   = 0;
    int                                 merges  = 0;
    int                                 results = 0;

    task automatic report_mismatch(input string msg);
        if (fails < 10) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        fails++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_a = 0;
            fill_b = 0;
            merged_q.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                results++;
                if (merged_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value=%h last=%b",
                                              i_m_axis_tdata, i_m_axis_tlast));
                end else begin
                    oldest = merged_q.pop_front();
                    if (oldest.value !== i_m_axis_tdata ||
                        oldest.last !== i_m_axis_tlast) begin
                        report_mismatch($sformatf(
                            "expected value=%h last=%b, actual value=%h last=%b",
                            oldest.value, oldest.last, i_m_axis_tdata, i_m_axis_tlast));
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                case (stlm_pkg::t_kind'(i_s_axis_tuser))
                    stlm_pkg::KIND_LOAD_A: begin
                        if (fill_a < LIST_DEPTH) begin
                            list_a[fill_a] = i_s_axis_tdata;
                            fill_a++;
                        end
                    end
                    stlm_pkg::KIND_LOAD_B: begin
                        if (fill_b < LIST_DEPTH) begin
                            list_b[fill_b] = i_s_axis_tdata;
                            fill_b++;
                        end
                    end
                    stlm_pkg::KIND_MERGE: begin
                        merges++;
                        total = fill_a + fill_b;
                        ia    = 0;
                        ib    = 0;
                        for (int n = 0; n < total; n++) begin
                            if (ia < fill_a && ib < fill_b) begin
                                if (list_a[ia] < list_b[ib]) begin
                                    head = list_a[ia];
                                    ia++;
                                end else begin
                                    head = list_b[ib];
                                    ib++;
                                end
                            end else if (ia < fill_a) begin
                                head = list_a[ia];
                                ia++;
                            end else begin
                                head = list_b[ib];
                                ib++;
                            end
                            merged_q.push_back('{value: head, last: (n == total - 1)});
                        end
                        fill_a = 0;
                        fill_b = 0;
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending    <= merged_q.size();
        o_fail_count <= fails;
        o_merges     <= merges;
        o_results    <= results;
    end

endmodule

// ===== sim/tb.sv =====
// Top of the testbench for the sorted two-list merge core: clock, reset,
// stimulus over four phases of input idling and output stalling, watchdog and verdict.
// Depends on stlm_pkg, sorted_two_list_merge_core and stlm_merge_checker.
`timescale 1ns / 1ps

module tb;

    localparam int LIST_DEPTH    = stlm_pkg::DEFAULT_LIST_DEPTH;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 14;
    localparam int TAIL_CYCLES   = 20;

    logic                        i_clk            = 1'b0;
    logic                        i_rst_n          = 1'b0;
    logic                        i_s_axis_tvalid  = 1'b0;
    logic                        o_s_axis_tready;
    logic [stlm_pkg::DATA_W-1:0] i_s_axis_tdata   = '0;   // [31:0] item_value
    logic [stlm_pkg::KIND_W-1:0] i_s_axis_tuser   = '0;   // [1:0] kind
    logic                        o_m_axis_tvalid;
    logic                        i_m_axis_tready  = 1'b0;
    logic [stlm_pkg::DATA_W-1:0] o_m_axis_tdata;          // [31:0] out_value
    logic                        o_m_axis_tlast;          // out_last

    int fail_count;
    int pending;
    int merges;
    int results;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int items_sent = 0;
    int bursts     = 0;
    int quiet      = 0;

    always #6 i_clk = ~i_clk;

    sorted_two_list_merge_core #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    stlm_merge_checker #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .i_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .i_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .i_m_axis_tdata (o_m_axis_tdata),
        .i_m_axis_tlast (o_m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_merges       (merges),
        .o_results      (results)
    );

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("Watchdog: no channel activity for %0d cycles.", QUIET_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic send_item(input stlm_pkg::t_kind kind,
                             input logic [stlm_pkg::DATA_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        i_s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (kind != stlm_pkg::KIND_NONE) begin
            items_sent++;
        end
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
    endtask

    task automatic run_burst(input int len_a, input int len_b, input bit sorted);
        logic [stlm_pkg::DATA_W-1:0] vals_a [$];
        logic [stlm_pkg::DATA_W-1:0] vals_b [$];
        longint                      cur;
        longint                      step;
        int                          mode;
        int                          len;
        mode = $urandom_range(0, 2);
        for (int side = 0; side < 2; side++) begin
            len = (side == 0) ? len_a : len_b;
            case (mode)
                0:       cur = longint'($urandom_range(0, 16)) - 8;
                1:       cur = longint'($signed($urandom));
                default: cur = -64'sd2147483648 + longint'($urandom_range(0, 3));
            endcase
            for (int k = 0; k < len; k++) begin
                if (!sorted) begin
                    cur = longint'($signed($urandom));
                end
                if (side == 0) begin
                    vals_a.push_back(cur[stlm_pkg::DATA_W-1:0]);
                end else begin
                    vals_b.push_back(cur[stlm_pkg::DATA_W-1:0]);
                end
                case (mode)
                    0:       step = longint'($urandom_range(0, 3));
                    1:       step = longint'($urandom_range(0, 32'h0800_0000));
                    default: step = longint'($urandom_range(0, 32'h7FFF_FFFF)) * 2;
                endcase
                cur = cur + step;
                if (cur > 64'sd2147483647) begin
                    cur = 64'sd2147483647;
                end
            end
        end
        while (vals_a.size() != 0 || vals_b.size() != 0) begin
            if ($urandom_range(9) == 0) begin
                send_item(stlm_pkg::KIND_NONE, $urandom);
            end
            if (vals_b.size() == 0 || (vals_a.size() != 0 && $urandom_range(1) == 1)) begin
                send_item(stlm_pkg::KIND_LOAD_A, vals_a.pop_front());
            end else begin
                send_item(stlm_pkg::KIND_LOAD_B, vals_b.pop_front());
            end
        end
        send_item(stlm_pkg::KIND_MERGE, $urandom);
        if ($urandom_range(3) == 0) begin
            drain_results();
        end
    endtask

    initial begin
        int phase_start;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(stlm_pkg::KIND_MERGE,  32'h0000_0000);
        send_item(stlm_pkg::KIND_NONE,   32'hFFFF_FFFF);
        send_item(stlm_pkg::KIND_LOAD_A, 32'h8000_0000);
        send_item(stlm_pkg::KIND_LOAD_A, 32'hFFFF_FFFB);
        send_item(stlm_pkg::KIND_LOAD_B, 32'h8000_0000);
        send_item(stlm_pkg::KIND_LOAD_A, 32'h0000_0000);
        send_item(stlm_pkg::KIND_LOAD_B, 32'h0000_0000);
        send_item(stlm_pkg::KIND_LOAD_B, 32'h0000_0007);
        send_item(stlm_pkg::KIND_NONE,   32'h0000_0000);
        send_item(stlm_pkg::KIND_LOAD_A, 32'h7FFF_FFFF);
        send_item(stlm_pkg::KIND_LOAD_B, 32'h7FFF_FFFF);
        send_item(stlm_pkg::KIND_MERGE,  32'hA5A5_5A5A);
        send_item(stlm_pkg::KIND_LOAD_A, 32'h0000_0001);
        send_item(stlm_pkg::KIND_LOAD_A, 32'h0000_0002);
        send_item(stlm_pkg::KIND_LOAD_A, 32'h0000_0003);
        send_item(stlm_pkg::KIND_MERGE,  32'hFFFF_FFFF);
        send_item(stlm_pkg::KIND_LOAD_B, 32'hFFFF_FFFF);
        send_item(stlm_pkg::KIND_MERGE,  32'h0000_0000);
        send_item(stlm_pkg::KIND_LOAD_A, 32'h0000_000A);
        send_item(stlm_pkg::KIND_LOAD_B, 32'h0000_0005);
        send_item(stlm_pkg::KIND_LOAD_A, 32'hFFFF_FFFD);
        send_item(stlm_pkg::KIND_LOAD_B, 32'hFFFF_FFEC);
        send_item(stlm_pkg::KIND_MERGE,  32'h5555_AAAA);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 46; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 46; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            phase_start = items_sent;
            while (items_sent < phase_start + PHASE_ITEMS) begin
                bursts++;
                if (bursts == 4) begin
                    run_burst(LIST_DEPTH + 1, 3, 1'b1);
                end else begin
                    run_burst($urandom_range(0, 6), $urandom_range(0, 6),
                              $urandom_range(4) != 0);
                end
            end
            drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Summary: %0d items in %0d bursts, %0d merges, %0d results checked.",
                 items_sent, bursts, merges, results);
        $display("Covered ties, empty and one-sided merges, unsorted lists, full-list drops.");
        if (fail_count == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
